// ===== sv/sfa_pkg.sv =====
// Shared types and constants of the shape footprint area block.
package sfa_pkg;

    localparam int AREA_W  = 56;   // Q.16 area result
    localparam int SUM_W   = 57;   // cross product accumulator
    localparam int PI_W    = 18;
    localparam int PI_FRAC = 18;   // pi is scaled by 2^16, the square of x by 2^-2: net shift 18

    localparam logic [PI_W-1:0] PI_Q16 = 18'd205887;

    typedef enum logic [1:0] {
        MODE_RECT   = 2'd0,
        MODE_CIRCLE = 2'd1,
        MODE_POLY   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VERT,
        S_MUL_A,
        S_MUL_B,
        S_DIFF,
        S_SUM,
        S_PI_HI,
        S_PI_LO,
        S_PI_ADD,
        S_FINAL
    } t_state;

endpackage

// ===== sv/sfa_mul.sv =====
// Shared signed multiplier with a registered product.
module sfa_mul #(
    parameter int MW = 25
) (
    input  logic                   i_clk,
    input  logic signed [MW-1:0]   i_a,
    input  logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0] o_p
);

    logic signed [2*MW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (2*MW)'(i_a) * (2*MW)'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== sv/shape_footprint_area.sv =====
// Top level of the shape footprint area block: sequencer, accumulator and output register.
//
// Usage
//   Input channel (i_valid / o_ready) takes one item: i_mode selects a rectangle
//   (area = x * y), a circle (area = (x/2)^2 * pi, truncated) or a polygon vertex.
//   Vertices of a polygon stream in one item each; i_last_vertex closes the ring
//   and yields the shoelace area, floor of half the saturated cross product sum.
//   Output channel (o_valid / i_ready) carries o_area (Q.16, saturated to 56 bits)
//   and o_shape_kind (the mode). A non-final vertex gives no result.
//   Rate: one item at a time; all products go through one registered multiplier.
//   The result shows on the output the cycle after the sequencer's final step.
//   Steps: a rectangle multiplies once; a circle squares, then scales both
//   halves of the square by pi; a later vertex adds its edge's cross product to the sum.
//   The output register frees the datapath: a result waits there while the
//   next item is worked on; if a second result finds it still full, the
//   sequencer holds in its final step until the receiver takes the first.
//   Reset (i_rst_n low, synchronous) returns to idle, drops any pending result
//   and closes any open polygon.
module shape_footprint_area #(
    parameter int COORD_WIDTH  = 24,
    parameter int MAX_VERTICES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic                          i_last_vertex,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [sfa_pkg::AREA_W-1:0] o_area,
    output logic [1:0]                    o_shape_kind
);

    // Multiplier operand width: a coordinate magnitude or the pi constant.
    localparam int MW    = (COORD_WIDTH + 1 > sfa_pkg::PI_W + 1) ?
                           COORD_WIDTH + 1 : sfa_pkg::PI_W + 1;
    localparam int PW    = 2 * MW;
    // Working register: holds products, clamped differences and the circle sum.
    localparam int AW    = (2 * COORD_WIDTH + 20 > 60) ? 2 * COORD_WIDTH + 20 : 60;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int SW    = sfa_pkg::SUM_W;
    localparam int RW    = sfa_pkg::AREA_W;

    localparam logic signed [SW-1:0] SUM_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN  = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [RW-1:0] AREA_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic signed [RW-1:0] AREA_MIN = {1'b1, {(RW-1){1'b0}}};

    localparam logic signed [AW-1:0] D_HI   = AW'(SUM_MAX) + AW'(1);
    localparam logic signed [AW-1:0] D_LO   = AW'(SUM_MIN) - AW'(1);
    localparam logic signed [AW:0]   S_HI   = (AW+1)'(SUM_MAX);
    localparam logic signed [AW:0]   S_LO   = (AW+1)'(SUM_MIN);
    localparam logic signed [AW-1:0] A_HI   = AW'(AREA_MAX);
    localparam logic signed [AW-1:0] A_LO   = AW'(AREA_MIN);

    sfa_pkg::t_state r_state, n_state;
    sfa_pkg::t_mode  r_mode, n_mode;

    logic signed [COORD_WIDTH-1:0] r_x, n_x, r_y, n_y;
    logic signed [COORD_WIDTH-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [COORD_WIDTH-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic                          r_last, n_last;
    logic                          r_close, n_close;     // working on the ring closing edge
    logic                          r_open, n_open;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic signed [SW-1:0]          r_sum, n_sum;
    logic signed [AW-1:0]          r_acc, n_acc;
    logic                          r_out_valid, n_out_valid;
    logic signed [RW-1:0]          r_area, n_area;
    logic [1:0]                    r_kind, n_kind;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] prod_ext;
    logic signed [COORD_WIDTH:0] x_ext, x_abs;
    logic signed [AW-1:0] diff;
    logic signed [AW:0]   sum_wide;
    logic signed [AW-1:0] circ_q;
    logic signed [SW-1:0] half_sum;
    logic signed [MW-1:0] op_pi, op_sq_hi, op_sq_lo;
    logic                 load_out;

    sfa_mul #(.MW(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Datapath helpers feeding the sequencer.
    assign prod_ext = AW'(prod);
    assign x_ext    = (COORD_WIDTH+1)'(r_x);
    assign x_abs    = r_x[COORD_WIDTH-1] ? -x_ext : x_ext;
    assign diff     = r_acc - prod_ext;
    assign sum_wide = (AW+1)'(r_sum) + (AW+1)'(r_acc);
    assign circ_q   = r_acc >>> sfa_pkg::PI_FRAC;
    assign half_sum = r_sum >>> 1;
    assign op_pi    = MW'($signed({1'b0, sfa_pkg::PI_Q16}));
    // Square split in two halves so each pi product stays in the shared multiplier.
    assign op_sq_hi = MW'($signed({1'b0, r_acc[2*COORD_WIDTH-1:COORD_WIDTH]}));
    assign op_sq_lo = MW'($signed({1'b0, r_acc[COORD_WIDTH-1:0]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_open      <= 1'b0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_close     <= 1'b0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_open      <= n_open;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_close     <= n_close;
            r_first_x   <= n_first_x;
            r_first_y   <= n_first_y;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_x    <= n_x;
        r_y    <= n_y;
        r_last <= n_last;
        r_acc  <= n_acc;
        r_area <= n_area;
        r_kind <= n_kind;
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_x       = r_x;
        n_y       = r_y;
        n_last    = r_last;
        n_close   = r_close;
        n_open    = r_open;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_acc     = r_acc;
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_area    = r_area;
        n_kind    = r_kind;
        mul_a     = '0;
        mul_b     = '0;
        load_out  = 1'b0;

        unique case (r_state)
            sfa_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_x     = i_coord_x;
                    n_y     = i_coord_y;
                    n_last  = i_last_vertex;
                    n_mode  = sfa_pkg::t_mode'(i_mode);
                    n_close = 1'b0;
                    unique case (sfa_pkg::t_mode'(i_mode))
                        sfa_pkg::MODE_RECT,
                        sfa_pkg::MODE_CIRCLE: n_state = sfa_pkg::S_MUL_A;
                        sfa_pkg::MODE_POLY:   n_state = sfa_pkg::S_VERT;
                        sfa_pkg::MODE_NONE:   n_state = sfa_pkg::S_FINAL;
                    endcase
                end
            end
            sfa_pkg::S_VERT: begin
                priority if (!r_open) begin
                    // Opening vertex: ring starts here, empty sum.
                    n_first_x = r_x;
                    n_first_y = r_y;
                    n_prev_x  = r_x;
                    n_prev_y  = r_y;
                    n_sum     = '0;
                    n_open    = 1'b1;
                    n_cnt     = CNT_W'(1);
                    n_state   = r_last ? sfa_pkg::S_FINAL : sfa_pkg::S_IDLE;
                end else if (r_cnt < CNT_W'(MAX_VERTICES) || r_last) begin
                    n_state = sfa_pkg::S_MUL_A;
                end else begin
                    // Vertex over the limit and not closing: dropped.
                    n_state = sfa_pkg::S_IDLE;
                end
            end
            sfa_pkg::S_MUL_A: begin
                unique case (r_mode)
                    sfa_pkg::MODE_RECT: begin
                        mul_a = MW'(r_x);
                        mul_b = MW'(r_y);
                    end
                    sfa_pkg::MODE_CIRCLE: begin
                        mul_a = MW'(x_abs);
                        mul_b = MW'(x_abs);
                    end
                    default: begin
                        mul_a = r_close ? MW'(r_x) : MW'(r_prev_x);
                        mul_b = r_close ? MW'(r_first_y) : MW'(r_y);
                    end
                endcase
                n_state = sfa_pkg::S_MUL_B;
            end
            sfa_pkg::S_MUL_B: begin
                n_acc = prod_ext;
                unique case (r_mode)
                    sfa_pkg::MODE_RECT:   n_state = sfa_pkg::S_FINAL;
                    sfa_pkg::MODE_CIRCLE: n_state = sfa_pkg::S_PI_HI;
                    default: begin
                        mul_a   = r_close ? MW'(r_first_x) : MW'(r_x);
                        mul_b   = r_close ? MW'(r_y) : MW'(r_prev_y);
                        n_state = sfa_pkg::S_DIFF;
                    end
                endcase
            end
            sfa_pkg::S_DIFF: begin
                // Cross product, clamped one past the accumulator range.
                priority if (diff > D_HI) begin
                    n_acc = D_HI;
                end else if (diff < D_LO) begin
                    n_acc = D_LO;
                end else begin
                    n_acc = diff;
                end
                n_state = sfa_pkg::S_SUM;
            end
            sfa_pkg::S_SUM: begin
                priority if (sum_wide > S_HI) begin
                    n_sum = SUM_MAX;
                end else if (sum_wide < S_LO) begin
                    n_sum = SUM_MIN;
                end else begin
                    n_sum = SW'(sum_wide);
                end
                if (r_close) begin
                    n_state = sfa_pkg::S_FINAL;
                end else begin
                    n_prev_x = r_x;
                    n_prev_y = r_y;
                    n_cnt    = r_cnt + CNT_W'(1);
                    if (r_last) begin
                        n_close = 1'b1;
                        n_state = sfa_pkg::S_MUL_A;
                    end else begin
                        n_state = sfa_pkg::S_IDLE;
                    end
                end
            end
            sfa_pkg::S_PI_HI: begin
                mul_a   = op_sq_hi;
                mul_b   = op_pi;
                n_state = sfa_pkg::S_PI_LO;
            end
            sfa_pkg::S_PI_LO: begin
                mul_a   = op_sq_lo;
                mul_b   = op_pi;
                n_acc   = prod_ext <<< COORD_WIDTH;
                n_state = sfa_pkg::S_PI_ADD;
            end
            sfa_pkg::S_PI_ADD: begin
                n_acc   = r_acc + prod_ext;
                n_state = sfa_pkg::S_FINAL;
            end
            sfa_pkg::S_FINAL: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_kind   = r_mode;
                    n_state  = sfa_pkg::S_IDLE;
                    unique case (r_mode)
                        sfa_pkg::MODE_RECT: begin
                            priority if (r_acc > A_HI) begin
                                n_area = AREA_MAX;
                            end else if (r_acc < A_LO) begin
                                n_area = AREA_MIN;
                            end else begin
                                n_area = RW'(r_acc);
                            end
                        end
                        sfa_pkg::MODE_CIRCLE: begin
                            n_area = (circ_q > A_HI) ? AREA_MAX : RW'(circ_q);
                        end
                        sfa_pkg::MODE_POLY: begin
                            n_area = RW'(half_sum);
                            n_open = 1'b0;
                            n_cnt  = '0;
                            n_sum  = '0;
                        end
                        sfa_pkg::MODE_NONE: begin
                            n_area = '0;
                        end
                    endcase
                end
            end
        endcase

        n_out_valid = load_out ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    assign o_ready      = (r_state == sfa_pkg::S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_area       = r_area;
    assign o_shape_kind = r_kind;

endmodule

// ===== sv/sfa_check.sv =====
// Port-level checker for the shape footprint area block, bound to the top level.
module sfa_check #(
    parameter int COORD_WIDTH = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [1:0]                    i_mode,
    input logic signed [COORD_WIDTH-1:0] i_coord_x,
    input logic signed [COORD_WIDTH-1:0] i_coord_y,
    input logic                          i_last_vertex,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [sfa_pkg::AREA_W-1:0] o_area,
    input logic [1:0]                    o_shape_kind
);

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_area) && $stable(o_shape_kind))
        else $error("stalled result changed");

    // One item at a time: taking an item drops ready.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");

    // Unused mode gives a zero area.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_shape_kind == sfa_pkg::MODE_NONE |-> o_area == '0)
        else $error("unused mode gave nonzero area");

    // A circle area is never negative.
    a_circle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_shape_kind == sfa_pkg::MODE_CIRCLE |-> !o_area[sfa_pkg::AREA_W-1])
        else $error("negative circle area");

endmodule

bind shape_footprint_area sfa_check #(.COORD_WIDTH(COORD_WIDTH)) u_sfa_check (.*);
